// File: rtl/tzr_pkg.sv
// Shared constants, codes and types for the triangle z-buffer rasterizer.
package tzr_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_FACES  = 4096;
   localparam int NPIX       = MAX_WIDTH * MAX_HEIGHT;
   localparam int PIX_AW     = $clog2(NPIX);
   localparam int FACE_AW    = $clog2(MAX_FACES);

   localparam logic [31:0]        DEPTH_EMPTY = 32'hFFFF_FFFF;
   localparam logic [31:0]        DEPTH_SAT   = 32'hFFFF_FFFE;
   localparam logic signed [12:0] FACE_NONE   = -13'sd1;

   typedef enum logic [2:0] {
      FUNC_CLEAR      = 3'd0,
      FUNC_MASK_SET   = 3'd1,
      FUNC_MASK_CLR   = 3'd2,
      FUNC_TRIANGLE   = 3'd3,
      FUNC_READ_PIXEL = 3'd4,
      FUNC_FACE_QUERY = 3'd5,
      FUNC_FINISH     = 3'd6,
      FUNC_NOP        = 3'd7
   } func_type;

   typedef enum logic {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECODE, ST_SWEEP, ST_RDWAIT, ST_QWAIT, ST_FCLR, ST_FSCAN,
      ST_FDRAIN, ST_BOX, ST_SETUP, ST_AREA, ST_DIV, ST_MAC, ST_PX_READ,
      ST_PX_CHECK, ST_UPD, ST_NEXT, ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      DK_R0, DK_R1, DK_R2, DK_L0, DK_L1, DK_CAND
   } div_kind_type;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [15:0] vx0;
      logic signed [15:0] vy0;
      logic signed [15:0] vx1;
      logic signed [15:0] vy1;
      logic signed [15:0] vx2;
      logic signed [15:0] vy2;
      logic [31:0]        depth_a;
      logic [31:0]        depth_b;
      logic [31:0]        depth_c;
      logic [11:0]        face_number;
      logic [15:0]        pixel_index;
   } req_type;

   typedef struct packed {
      logic signed [12:0] pixel_face;
      logic               face_seen;
      logic [16:0]        visible_pixels;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        depth;
      logic signed [12:0] face;
   } zf_type;

   typedef struct packed {
      logic [63:0]  rem;
      logic [63:0]  quo;
      logic [63:0]  den;
      logic [5:0]   cnt;
      div_kind_type kind;
   } div_type;

   typedef struct packed {
      logic signed [16:0] a0;
      logic signed [16:0] b0;
      logic signed [16:0] a1;
      logic signed [16:0] b1;
      logic signed [17:0] dx;
      logic signed [17:0] dy;
      logic [7:0]         c0;
      logic [7:0]         c1;
      logic [7:0]         rw1;
      logic [7:0]         col;
      logic [7:0]         row;
      logic [15:0]        prow;
      logic signed [39:0] d;
      logic signed [39:0] n0;
      logic signed [39:0] n1;
      logic signed [39:0] n0row;
      logic signed [39:0] n1row;
      logic signed [39:0] e0;
      logic signed [39:0] e1;
      logic               neg;
      logic [46:0]        r0;
      logic [46:0]        r1;
      logic [46:0]        r2;
      logic [16:0]        l0;
      logic [16:0]        l1;
      zf_type             old;
      logic [31:0]        cand;
      logic [2:0]         step;
      logic [16:0]        mac_l;
      logic [62:0]        mac_r;
      logic [63:0]        acc;
      logic [1:0]         pass;
      logic [4:0]         mcnt;
   } tri_type;

endpackage

// File: rtl/tzr_ram.sv
// Generic single-port RAM with registered read data.
module tzr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/triangle_zbuffer_face_id_rasterizer_top.sv
// Top level of the triangle rasterizer with depth, face-id, mask and face-flag stores.
//
// Channel   Direction  Signals                       Beat
// req       in         req_valid/req_ready/req_data  one command
// rsp       out        rsp_valid/rsp_ready/rsp_data  one result per command
// csr       in         csr_we/csr_index/csr_wdata    one register write
//
// After reset a clearing pass over all 65536 pixel addresses runs before the first command is taken.
// Clear sweeps all 65536 pixel addresses; finish clears the 4096 face flags, then scans width*height pixels.
// A triangle runs a setup pass, then walks each pixel of its clipped bounding box; each covered
// pixel goes through the shared 64-step divider and 17-step shift-add multiplier.
// A new command is taken while an earlier result still waits on rsp.
module triangle_zbuffer_face_id_rasterizer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tzr_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tzr_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [8:0]        csr_wdata
);

   tzr_pkg::state_type state_ff, state_in;
   tzr_pkg::req_type   req_ff, req_in;
   tzr_pkg::rsp_type   res_ff, res_in;
   tzr_pkg::rsp_type   rsp_ff, rsp_in;
   tzr_pkg::tri_type   tri_ff, tri_in;
   tzr_pkg::div_type   div_ff, div_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [8:0]         width_ff, width_in;
   logic [8:0]         height_ff, height_in;
   logic [16:0]        npx_ff, npx_in;
   logic [16:0]        cnt_ff, cnt_in;
   logic [16:0]        count_ff, count_in;
   logic               init_ff, init_in;
   logic               scan_vld_ff, scan_vld_in;

   logic [8:0]                   weff, heff;
   logic                         zf_we, mask_we, flag_we;
   logic [tzr_pkg::PIX_AW-1:0]   zf_addr, mask_addr;
   logic [tzr_pkg::FACE_AW-1:0]  flag_addr;
   tzr_pkg::zf_type              zf_wdata, zf_rd;
   logic                         mask_wdata, mask_rd, flag_wdata, flag_rd;
   logic [15:0]                  pix;

   logic signed [15:0] minx, maxx, miny, maxy;
   logic signed [17:0] wlim, hlim, cx, fx, cy, fy;
   logic [7:0]         bc0, bc1, br0, br1;
   logic               box_skip;
   logic signed [16:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [34:0] mul_p;
   logic [64:0]        div_sh;
   logic               div_ge;
   logic [63:0]        div_q;
   logic [63:0]        acc_new;
   logic signed [39:0] e2;
   logic               wins;
   logic               scan_hit;
   logic [16:0]        count_new;

   function automatic tzr_pkg::div_type div_start(input logic [63:0] num,
                                                   input logic [63:0] den,
                                                   input tzr_pkg::div_kind_type kind);
      tzr_pkg::div_type v;
      v.rem  = '0;
      v.quo  = num;
      v.den  = den;
      v.cnt  = '0;
      v.kind = kind;
      return v;
   endfunction

   function automatic logic [7:0] clamp_dim(input logic signed [17:0] v, input logic [8:0] dim);
      logic [8:0]         top;
      logic signed [17:0] hi;
      top = dim - 9'd1;
      hi  = $signed({9'b0, top});
      if (v < 0) begin
         return 8'd0;
      end else if (v > hi) begin
         return top[7:0];
      end
      return v[7:0];
   endfunction

   function automatic logic signed [15:0] min3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
      logic signed [15:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic signed [15:0] max3(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic signed [15:0] c);
      logic signed [15:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   tzr_ram #(.WIDTH($bits(tzr_pkg::zf_type)), .DEPTH(tzr_pkg::NPIX)) u_zf_ram (
      .clock (clock),
      .we    (zf_we),
      .addr  (zf_addr),
      .wdata (zf_wdata),
      .rdata (zf_rd)
   );

   tzr_ram #(.WIDTH(1), .DEPTH(tzr_pkg::NPIX)) u_mask_ram (
      .clock (clock),
      .we    (mask_we),
      .addr  (mask_addr),
      .wdata (mask_wdata),
      .rdata (mask_rd)
   );

   tzr_ram #(.WIDTH(1), .DEPTH(tzr_pkg::MAX_FACES)) u_flag_ram (
      .clock (clock),
      .we    (flag_we),
      .addr  (flag_addr),
      .wdata (flag_wdata),
      .rdata (flag_rd)
   );

   always_comb begin
      weff = (width_ff == 9'd0) ? 9'd1 :
             (width_ff > 9'(tzr_pkg::MAX_WIDTH)) ? 9'(tzr_pkg::MAX_WIDTH) : width_ff;
      heff = (height_ff == 9'd0) ? 9'd1 :
             (height_ff > 9'(tzr_pkg::MAX_HEIGHT)) ? 9'(tzr_pkg::MAX_HEIGHT) : height_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tzr_pkg::ST_SWEEP;
         rsp_valid_ff <= 1'b0;
         width_ff     <= 9'(tzr_pkg::MAX_WIDTH);
         height_ff    <= 9'(tzr_pkg::MAX_HEIGHT);
         npx_ff       <= 17'(tzr_pkg::NPIX);
         cnt_ff       <= '0;
         count_ff     <= '0;
         init_ff      <= 1'b1;
         scan_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         npx_ff       <= npx_in;
         cnt_ff       <= cnt_in;
         count_ff     <= count_in;
         init_ff      <= init_in;
         scan_vld_ff  <= scan_vld_in;
      end
      req_ff <= req_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
      tri_ff <= tri_in;
      div_ff <= div_in;
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            tzr_pkg::CSR_WIDTH:  width_in  = csr_wdata;
            tzr_pkg::CSR_HEIGHT: height_in = csr_wdata;
            default:             width_in  = width_ff;
         endcase
      end
      npx_in = 17'({8'b0, weff} * {8'b0, heff});
   end

   // Triangle bounding box, clipped to the image.
   always_comb begin
      minx = min3(req_ff.vx0, req_ff.vx1, req_ff.vx2);
      maxx = max3(req_ff.vx0, req_ff.vx1, req_ff.vx2);
      miny = min3(req_ff.vy0, req_ff.vy1, req_ff.vy2);
      maxy = max3(req_ff.vy0, req_ff.vy1, req_ff.vy2);
      wlim = $signed({5'b0, weff - 9'd1, 4'b0});
      hlim = $signed({5'b0, heff - 9'd1, 4'b0});
      cx   = (18'(minx) + 18'sd15) >>> 4;
      fx   = 18'(maxx) >>> 4;
      cy   = (18'(miny) + 18'sd15) >>> 4;
      fy   = 18'(maxy) >>> 4;
      bc0  = clamp_dim(cx, weff);
      bc1  = clamp_dim(fx, weff);
      br0  = clamp_dim(cy, heff);
      br1  = clamp_dim(fy, heff);
      box_skip = (req_ff.depth_a == 32'd0) || (req_ff.depth_b == 32'd0) ||
                 (req_ff.depth_c == 32'd0) || (maxx < 0) || (maxy < 0) ||
                 (18'(minx) > wlim) || (18'(miny) > hlim) || (bc0 > bc1) || (br0 > br1);
   end

   always_comb begin
      case (tri_ff.step)
         3'd0:    begin mul_a = tri_ff.a0; mul_b = 18'(tri_ff.b1); end
         3'd1:    begin mul_a = tri_ff.b0; mul_b = 18'(tri_ff.a1); end
         3'd2:    begin mul_a = tri_ff.a0; mul_b = tri_ff.dx; end
         3'd3:    begin mul_a = tri_ff.b0; mul_b = tri_ff.dy; end
         3'd4:    begin mul_a = tri_ff.a1; mul_b = tri_ff.dx; end
         default: begin mul_a = tri_ff.b1; mul_b = tri_ff.dy; end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      div_sh  = {div_ff.rem, div_ff.quo[63]};
      div_ge  = div_sh >= {1'b0, div_ff.den};
      div_q   = {div_ff.quo[62:0], div_ge};
      acc_new = tri_ff.mac_l[0] ? tri_ff.acc + {1'b0, tri_ff.mac_r} : tri_ff.acc;
      e2      = tri_ff.d - tri_ff.e0 - tri_ff.e1;
      wins    = (tri_ff.cand < tri_ff.old.depth) ||
                ((tri_ff.cand == tri_ff.old.depth) &&
                 ($signed({1'b0, req_ff.face_number}) < tri_ff.old.face));
      scan_hit  = scan_vld_ff && !zf_rd.face[12];
      count_new = scan_hit ? count_ff + 17'd1 : count_ff;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      tri_in       = tri_ff;
      div_in       = div_ff;
      cnt_in       = cnt_ff;
      count_in     = count_ff;
      init_in      = init_ff;
      scan_vld_in  = scan_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      pix          = 16'(tri_ff.prow + {8'b0, tri_ff.col});
      zf_we        = 1'b0;
      zf_addr      = pix;
      zf_wdata     = '{depth: tri_ff.cand, face: $signed({1'b0, req_ff.face_number})};
      mask_we      = 1'b0;
      mask_addr    = pix;
      mask_wdata   = 1'b0;
      flag_we      = 1'b0;
      flag_addr    = req_ff.face_number;
      flag_wdata   = 1'b0;

      case (state_ff)
         tzr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_data;
               state_in = tzr_pkg::ST_DECODE;
            end
         end

         tzr_pkg::ST_DECODE: begin
            res_in   = '0;
            state_in = tzr_pkg::ST_RESP;
            case (req_ff.func)
               tzr_pkg::FUNC_CLEAR: begin
                  cnt_in   = '0;
                  state_in = tzr_pkg::ST_SWEEP;
               end
               tzr_pkg::FUNC_MASK_SET, tzr_pkg::FUNC_MASK_CLR: begin
                  mask_addr  = req_ff.pixel_index;
                  mask_wdata = (req_ff.func == tzr_pkg::FUNC_MASK_SET);
                  mask_we    = {1'b0, req_ff.pixel_index} < npx_ff;
               end
               tzr_pkg::FUNC_TRIANGLE: state_in = tzr_pkg::ST_BOX;
               tzr_pkg::FUNC_READ_PIXEL: begin
                  zf_addr = req_ff.pixel_index;
                  if ({1'b0, req_ff.pixel_index} < npx_ff) begin
                     state_in = tzr_pkg::ST_RDWAIT;
                  end else begin
                     res_in.pixel_face = tzr_pkg::FACE_NONE;
                  end
               end
               tzr_pkg::FUNC_FACE_QUERY: state_in = tzr_pkg::ST_QWAIT;
               tzr_pkg::FUNC_FINISH: begin
                  cnt_in   = '0;
                  state_in = tzr_pkg::ST_FCLR;
               end
               default: state_in = tzr_pkg::ST_RESP;
            endcase
         end

         tzr_pkg::ST_SWEEP: begin
            zf_we      = 1'b1;
            zf_addr    = cnt_ff[15:0];
            zf_wdata   = '{depth: tzr_pkg::DEPTH_EMPTY, face: tzr_pkg::FACE_NONE};
            flag_we    = 1'b1;
            flag_addr  = cnt_ff[11:0];
            mask_we    = init_ff;
            mask_addr  = cnt_ff[15:0];
            cnt_in     = cnt_ff + 17'd1;
            if (cnt_ff[15:0] == 16'hFFFF) begin
               init_in  = 1'b0;
               state_in = init_ff ? tzr_pkg::ST_IDLE : tzr_pkg::ST_RESP;
            end
         end

         tzr_pkg::ST_RDWAIT: begin
            res_in.pixel_face = zf_rd.face;
            state_in          = tzr_pkg::ST_RESP;
         end

         tzr_pkg::ST_QWAIT: begin
            res_in.face_seen = flag_rd;
            state_in         = tzr_pkg::ST_RESP;
         end

         tzr_pkg::ST_FCLR: begin
            flag_we   = 1'b1;
            flag_addr = cnt_ff[11:0];
            cnt_in    = cnt_ff + 17'd1;
            if (cnt_ff[11:0] == 12'hFFF) begin
               cnt_in      = '0;
               count_in    = '0;
               scan_vld_in = 1'b0;
               state_in    = tzr_pkg::ST_FSCAN;
            end
         end

         tzr_pkg::ST_FSCAN, tzr_pkg::ST_FDRAIN: begin
            flag_we     = scan_hit;
            flag_addr   = zf_rd.face[11:0];
            flag_wdata  = 1'b1;
            count_in    = count_new;
            zf_addr     = cnt_ff[15:0];
            cnt_in      = cnt_ff + 17'd1;
            scan_vld_in = 1'b1;
            if (state_ff == tzr_pkg::ST_FDRAIN) begin
               scan_vld_in           = 1'b0;
               res_in.visible_pixels = count_new;
               state_in              = tzr_pkg::ST_RESP;
            end else if (cnt_ff == npx_ff - 17'd1) begin
               state_in = tzr_pkg::ST_FDRAIN;
            end
         end

         tzr_pkg::ST_BOX: begin
            if (box_skip) begin
               state_in = tzr_pkg::ST_RESP;
            end else begin
               tri_in.a0   = 17'(req_ff.vy1) - 17'(req_ff.vy2);
               tri_in.b0   = 17'(req_ff.vx2) - 17'(req_ff.vx1);
               tri_in.a1   = 17'(req_ff.vy2) - 17'(req_ff.vy0);
               tri_in.b1   = 17'(req_ff.vx0) - 17'(req_ff.vx2);
               tri_in.dx   = $signed({6'b0, bc0, 4'b0}) - 18'(req_ff.vx2);
               tri_in.dy   = $signed({6'b0, br0, 4'b0}) - 18'(req_ff.vy2);
               tri_in.c0   = bc0;
               tri_in.c1   = bc1;
               tri_in.rw1  = br1;
               tri_in.col  = bc0;
               tri_in.row  = br0;
               tri_in.prow = 16'({8'b0, br0} * {7'b0, weff});
               tri_in.step = '0;
               state_in    = tzr_pkg::ST_SETUP;
            end
         end

         tzr_pkg::ST_SETUP: begin
            tri_in.step = tri_ff.step + 3'd1;
            case (tri_ff.step)
               3'd0:    tri_in.d     = 40'(mul_p);
               3'd1:    tri_in.d     = tri_ff.d - 40'(mul_p);
               3'd2:    tri_in.n0row = 40'(mul_p);
               3'd3:    tri_in.n0row = tri_ff.n0row + 40'(mul_p);
               3'd4:    tri_in.n1row = 40'(mul_p);
               default: begin
                  tri_in.n1row = tri_ff.n1row + 40'(mul_p);
                  state_in     = tzr_pkg::ST_AREA;
               end
            endcase
         end

         tzr_pkg::ST_AREA: begin
            tri_in.n0 = tri_ff.n0row;
            tri_in.n1 = tri_ff.n1row;
            if (tri_ff.d == 40'sd0) begin
               state_in = tzr_pkg::ST_RESP;
            end else begin
               tri_in.neg = tri_ff.d < 0;
               tri_in.d   = (tri_ff.d < 0) ? -tri_ff.d : tri_ff.d;
               div_in     = div_start(64'h1 << 46, {32'b0, req_ff.depth_a}, tzr_pkg::DK_R0);
               state_in   = tzr_pkg::ST_DIV;
            end
         end

         tzr_pkg::ST_DIV: begin
            div_in.rem = div_ge ? 64'(div_sh - {1'b0, div_ff.den}) : div_sh[63:0];
            div_in.quo = div_q;
            div_in.cnt = div_ff.cnt + 6'd1;
            if (div_ff.cnt == 6'd63) begin
               case (div_ff.kind)
                  tzr_pkg::DK_R0: begin
                     tri_in.r0 = div_q[46:0];
                     div_in = div_start(64'h1 << 46, {32'b0, req_ff.depth_b}, tzr_pkg::DK_R1);
                  end
                  tzr_pkg::DK_R1: begin
                     tri_in.r1 = div_q[46:0];
                     div_in = div_start(64'h1 << 46, {32'b0, req_ff.depth_c}, tzr_pkg::DK_R2);
                  end
                  tzr_pkg::DK_R2: begin
                     tri_in.r2 = div_q[46:0];
                     state_in  = tzr_pkg::ST_PX_READ;
                  end
                  tzr_pkg::DK_L0: begin
                     tri_in.l0 = div_q[16:0];
                     div_in = div_start(64'(tri_ff.e1) << 16, 64'(tri_ff.d), tzr_pkg::DK_L1);
                  end
                  tzr_pkg::DK_L1: begin
                     tri_in.l1    = div_q[16:0];
                     tri_in.mac_l = tri_ff.l0;
                     tri_in.mac_r = 63'(tri_ff.r0);
                     tri_in.acc   = '0;
                     tri_in.pass  = 2'd0;
                     tri_in.mcnt  = '0;
                     state_in     = tzr_pkg::ST_MAC;
                  end
                  default: begin
                     tri_in.cand = (div_q > 64'(tzr_pkg::DEPTH_SAT)) ?
                                   tzr_pkg::DEPTH_SAT : div_q[31:0];
                     state_in    = tzr_pkg::ST_UPD;
                  end
               endcase
            end
         end

         tzr_pkg::ST_MAC: begin
            tri_in.acc   = acc_new;
            tri_in.mac_l = tri_ff.mac_l >> 1;
            tri_in.mac_r = tri_ff.mac_r << 1;
            tri_in.mcnt  = tri_ff.mcnt + 5'd1;
            if (tri_ff.mcnt == 5'd16) begin
               tri_in.mcnt = '0;
               tri_in.pass = tri_ff.pass + 2'd1;
               if (tri_ff.pass == 2'd0) begin
                  tri_in.mac_l = tri_ff.l1;
                  tri_in.mac_r = 63'(tri_ff.r1);
               end else if (tri_ff.pass == 2'd1) begin
                  tri_in.mac_l = 17'h1_0000 - tri_ff.l0 - tri_ff.l1;
                  tri_in.mac_r = 63'(tri_ff.r2);
               end else if (acc_new == 64'd0) begin
                  state_in = tzr_pkg::ST_NEXT;
               end else begin
                  div_in   = div_start(64'h1 << 62, acc_new, tzr_pkg::DK_CAND);
                  state_in = tzr_pkg::ST_DIV;
               end
            end
         end

         tzr_pkg::ST_PX_READ: begin
            tri_in.e0 = tri_ff.neg ? -tri_ff.n0 : tri_ff.n0;
            tri_in.e1 = tri_ff.neg ? -tri_ff.n1 : tri_ff.n1;
            state_in  = tzr_pkg::ST_PX_CHECK;
         end

         tzr_pkg::ST_PX_CHECK: begin
            tri_in.old = zf_rd;
            if (mask_rd && !tri_ff.e0[39] && !tri_ff.e1[39] && !e2[39]) begin
               div_in   = div_start(64'(tri_ff.e0) << 16, 64'(tri_ff.d), tzr_pkg::DK_L0);
               state_in = tzr_pkg::ST_DIV;
            end else begin
               state_in = tzr_pkg::ST_NEXT;
            end
         end

         tzr_pkg::ST_UPD: begin
            zf_we    = wins;
            state_in = tzr_pkg::ST_NEXT;
         end

         tzr_pkg::ST_NEXT: begin
            state_in = tzr_pkg::ST_PX_READ;
            if (tri_ff.col == tri_ff.c1) begin
               if (tri_ff.row == tri_ff.rw1) begin
                  state_in = tzr_pkg::ST_RESP;
               end else begin
                  tri_in.row   = tri_ff.row + 8'd1;
                  tri_in.col   = tri_ff.c0;
                  tri_in.prow  = tri_ff.prow + {7'b0, weff};
                  tri_in.n0row = tri_ff.n0row + (40'(tri_ff.b0) <<< 4);
                  tri_in.n1row = tri_ff.n1row + (40'(tri_ff.b1) <<< 4);
                  tri_in.n0    = tri_ff.n0row + (40'(tri_ff.b0) <<< 4);
                  tri_in.n1    = tri_ff.n1row + (40'(tri_ff.b1) <<< 4);
               end
            end else begin
               tri_in.col = tri_ff.col + 8'd1;
               tri_in.n0  = tri_ff.n0 + (40'(tri_ff.a0) <<< 4);
               tri_in.n1  = tri_ff.n1 + (40'(tri_ff.a1) <<< 4);
            end
         end

         tzr_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = tzr_pkg::ST_IDLE;
            end
         end

         default: state_in = tzr_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_cand_sat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tzr_pkg::ST_UPD) |-> (tri_ff.cand <= tzr_pkg::DEPTH_SAT))
      else $error("candidate depth above saturation value");

   a_weights: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tzr_pkg::ST_MAC) |-> (({1'b0, tri_ff.l0} + {1'b0, tri_ff.l1}) <= 18'h1_0000))
      else $error("barycentric weights exceed unity");

   a_in_box: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tzr_pkg::ST_PX_READ) |->
      (tri_ff.row <= tri_ff.rw1 && tri_ff.col <= tri_ff.c1 && tri_ff.col >= tri_ff.c0))
      else $error("pixel walk left the bounding box");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tzr_pkg::ST_DIV) |-> (div_ff.rem < div_ff.den))
      else $error("divider remainder not below divisor");
`endif

endmodule

// File: tb/triangle_zbuffer_face_id_rasterizer_checker.sv
`timescale 1ns / 100ps
// Checker that mirrors the rasterizer stores, predicts each result beat and compares it.
module triangle_zbuffer_face_id_rasterizer_checker
   import tzr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_ready,
   input  req_type  req_data,
   input  logic     rsp_valid,
   input  logic     rsp_ready,
   input  rsp_type  rsp_data,
   input  logic     csr_we,
   input  logic     csr_index,
   input  logic [8:0] csr_wdata,
   output int       fail_count
);

   bit [31:0]          depth_mem [NPIX];
   logic signed [12:0] face_mem  [NPIX];
   bit                 mask_mem  [NPIX];
   bit                 flag_mem  [MAX_FACES];
   bit [8:0]           width_reg;
   bit [8:0]           height_reg;
   rsp_type            expected_results [$];

   initial fail_count = 0;

   function automatic longint dim_in_use(bit [8:0] v, int limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic void clear_stores();
      for (int i = 0; i < NPIX; i++) begin
         depth_mem[i] = DEPTH_EMPTY;
         face_mem[i]  = FACE_NONE;
      end
      for (int i = 0; i < MAX_FACES; i++) flag_mem[i] = 0;
   endfunction

   function automatic void draw_triangle(req_type c);
      longint x0, y0, x1, y1, x2, y2, w, h;
      longint minx, maxx, miny, maxy, c0, c1, rw0, rw1, d, px, py, n0, n1, n2;
      longint unsigned z0, z1, z2, r0, r1, r2, ud, l0, l1, l2, inv, cand;
      int p;
      bit neg;
      x0 = $signed(c.vx0); y0 = $signed(c.vy0);
      x1 = $signed(c.vx1); y1 = $signed(c.vy1);
      x2 = $signed(c.vx2); y2 = $signed(c.vy2);
      z0 = c.depth_a; z1 = c.depth_b; z2 = c.depth_c;
      w = dim_in_use(width_reg, MAX_WIDTH);
      h = dim_in_use(height_reg, MAX_HEIGHT);
      if (z0 == 0 || z1 == 0 || z2 == 0) return;
      minx = x0 < x1 ? x0 : x1; minx = minx < x2 ? minx : x2;
      maxx = x0 > x1 ? x0 : x1; maxx = maxx > x2 ? maxx : x2;
      miny = y0 < y1 ? y0 : y1; miny = miny < y2 ? miny : y2;
      maxy = y0 > y1 ? y0 : y1; maxy = maxy > y2 ? maxy : y2;
      if (maxx < 0 || maxy < 0 || minx > (w - 1) * 16 || miny > (h - 1) * 16) return;
      c0  = clip(-((-minx) >>> 4), 0, w - 1);
      c1  = clip(maxx >>> 4, 0, w - 1);
      rw0 = clip(-((-miny) >>> 4), 0, h - 1);
      rw1 = clip(maxy >>> 4, 0, h - 1);
      if (c0 > c1 || rw0 > rw1) return;
      d = (y1 - y2) * (x0 - x2) + (x2 - x1) * (y0 - y2);
      if (d == 0) return;
      neg = d < 0;
      if (neg) d = -d;
      ud = d;
      r0 = (64'd1 << 46) / z0;
      r1 = (64'd1 << 46) / z1;
      r2 = (64'd1 << 46) / z2;
      for (longint row = rw0; row <= rw1; row++) begin
         for (longint col = c0; col <= c1; col++) begin
            p = int'(row * w + col);
            if (!mask_mem[p]) continue;
            px = col * 16;
            py = row * 16;
            n0 = (y1 - y2) * (px - x2) + (x2 - x1) * (py - y2);
            n1 = (y2 - y0) * (px - x2) + (x0 - x2) * (py - y2);
            if (neg) begin
               n0 = -n0;
               n1 = -n1;
            end
            n2 = d - n0 - n1;
            if (n0 < 0 || n1 < 0 || n2 < 0) continue;
            l0 = (longint'(n0) << 16) / ud;
            l1 = (longint'(n1) << 16) / ud;
            l2 = 65536 - l0 - l1;
            inv = l0 * r0 + l1 * r1 + l2 * r2;
            if (inv == 0) continue;
            cand = (64'd1 << 62) / inv;
            if (cand > DEPTH_SAT) cand = DEPTH_SAT;
            if (cand < depth_mem[p] ||
                (cand == depth_mem[p] && int'(c.face_number) < int'(face_mem[p]))) begin
               depth_mem[p] = cand;
               face_mem[p]  = c.face_number;
            end
         end
      end
   endfunction

   function automatic rsp_type predict_command(req_type c);
      rsp_type r;
      longint npx;
      int count;
      r = '0;
      npx = dim_in_use(width_reg, MAX_WIDTH) * dim_in_use(height_reg, MAX_HEIGHT);
      case (func_type'(c.func))
         FUNC_CLEAR: clear_stores();
         FUNC_MASK_SET: if (c.pixel_index < npx) mask_mem[c.pixel_index] = 1;
         FUNC_MASK_CLR: if (c.pixel_index < npx) mask_mem[c.pixel_index] = 0;
         FUNC_TRIANGLE: draw_triangle(c);
         FUNC_READ_PIXEL:
            r.pixel_face = c.pixel_index < npx ? face_mem[c.pixel_index] : FACE_NONE;
         FUNC_FACE_QUERY: r.face_seen = flag_mem[c.face_number];
         FUNC_FINISH: begin
            count = 0;
            for (int i = 0; i < MAX_FACES; i++) flag_mem[i] = 0;
            for (int i = 0; i < npx; i++) begin
               if (face_mem[i] >= 0) begin
                  count++;
                  flag_mem[face_mem[i]] = 1;
               end
            end
            r.visible_pixels = count;
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         width_reg  = MAX_WIDTH;
         height_reg = MAX_HEIGHT;
         clear_stores();
         for (int i = 0; i < NPIX; i++) mask_mem[i] = 0;
         expected_results.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_WIDTH) width_reg = csr_wdata;
            else height_reg = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result beat with nothing expected, got %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.pixel_face !== want.pixel_face) begin
                  $display("%0t: pixel_face expected %0d got %0d", $time,
                           want.pixel_face, rsp_data.pixel_face);
                  fail_count++;
               end
               if (rsp_data.face_seen !== want.face_seen) begin
                  $display("%0t: face_seen expected %0d got %0d", $time,
                           want.face_seen, rsp_data.face_seen);
                  fail_count++;
               end
               if (rsp_data.visible_pixels !== want.visible_pixels) begin
                  $display("%0t: visible_pixels expected %0d got %0d", $time,
                           want.visible_pixels, rsp_data.visible_pixels);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) expected_results.push_back(predict_command(req_data));
      end
   end

endmodule

// File: tb/triangle_zbuffer_face_id_rasterizer_top_tb.sv
`timescale 1ns / 100ps
// Testbench top: drives commands and register writes into the rasterizer and gives the verdict.
module triangle_zbuffer_face_id_rasterizer_top_tb;
   import tzr_pkg::*;

   localparam longint CYCLE_LIMIT = 40_000_000;
   localparam int     PHASES      = 9;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_we;
   logic       csr_index;
   logic [8:0] csr_wdata;
   int         fail_count;
   int         sent_count;
   int         got_count;
   int         triangle_count;
   longint     cycle_count;
   bit         held;
   req_type    last_triangle;
   bit [8:0]   width_list  [PHASES] = '{9'd0, 9'd511, 9'd13, 9'd256, 9'd3, 9'd8, 9'd1,
                                        9'd300, 9'd6};
   bit [8:0]   height_list [PHASES] = '{9'd0, 9'd5, 9'd9, 9'd256, 9'd511, 9'd8, 9'd200,
                                        9'd2, 9'd4};

   triangle_zbuffer_face_id_rasterizer_top uut (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   triangle_zbuffer_face_id_rasterizer_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_we, .csr_index, .csr_wdata, .fail_count
   );

   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_valid && req_ready) sent_count++;
      if (!reset && rsp_valid && rsp_ready) got_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 3);
      if (p < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 80);
   endfunction

   function automatic int dim_in_use(bit [8:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return v;
   endfunction

   function automatic logic [31:0] pick_depth();
      int p;
      p = $urandom_range(0, 99);
      if (p < 3) return 0;
      if (p < 6) return 1;
      if (p < 9) return 32'hFFFF_FFFF;
      if (p < 25) return $urandom;
      return $urandom_range(32'h4000, 32'h10_0000);
   endfunction

   function automatic req_type make_triangle(int w, int h, int ox, int oy);
      req_type r;
      int ax, ay;
      r = '0;
      r.func = FUNC_TRIANGLE;
      if (last_triangle.func == FUNC_TRIANGLE && $urandom_range(0, 99) < 8) begin
         r = last_triangle;
         r.face_number = $urandom_range(0, 15);
         return r;
      end
      if (w * h <= 64 && $urandom_range(0, 99) < 15) begin
         r.vx0 = $urandom; r.vy0 = $urandom; r.vx1 = $urandom;
         r.vy1 = $urandom; r.vx2 = $urandom; r.vy2 = $urandom;
      end else begin
         ax = (ox + $urandom_range(0, w - ox > 8 ? 7 : w - ox - 1)) * 16 + $urandom_range(0, 32) - 16;
         ay = (oy + $urandom_range(0, h - oy > 8 ? 7 : h - oy - 1)) * 16 + $urandom_range(0, 32) - 16;
         r.vx0 = 16'(ax + $urandom_range(0, 80) - 40);
         r.vy0 = 16'(ay + $urandom_range(0, 80) - 40);
         r.vx1 = 16'(ax + $urandom_range(0, 80) - 40);
         r.vy1 = 16'(ay + $urandom_range(0, 80) - 40);
         if ($urandom_range(0, 99) < 5) begin
            r.vx2 = r.vx0;
            r.vy2 = r.vy0;
         end else begin
            r.vx2 = 16'(ax + $urandom_range(0, 80) - 40);
            r.vy2 = 16'(ay + $urandom_range(0, 80) - 40);
         end
      end
      r.depth_a = pick_depth();
      r.depth_b = pick_depth();
      r.depth_c = pick_depth();
      r.face_number = $urandom_range(0, 99) < 70 ? $urandom_range(0, 15) : $urandom;
      return r;
   endfunction

   function automatic logic [15:0] window_pixel(int w, int h, int ox, int oy);
      if ($urandom_range(0, 99) < 10) return $urandom;
      return (oy + $urandom_range(0, h - oy > 8 ? 7 : h - oy - 1)) * w
             + ox + $urandom_range(0, w - ox > 8 ? 7 : w - ox - 1);
   endfunction

   function automatic req_type make_command(int w, int h, int ox, int oy);
      req_type r;
      int p;
      r = '0;
      r.face_number = $urandom;
      p = $urandom_range(0, 99);
      if (p < 25) r.func = FUNC_MASK_SET;
      else if (p < 30) r.func = FUNC_MASK_CLR;
      else if (p < 65) return make_triangle(w, h, ox, oy);
      else if (p < 85) r.func = FUNC_READ_PIXEL;
      else if (p < 94) begin
         r.func = FUNC_FACE_QUERY;
         if ($urandom_range(0, 1)) r.face_number = $urandom_range(0, 15);
      end else if (p < 98) r.func = (w * h > 4096 && p > 94) ? FUNC_NOP : FUNC_FINISH;
      else r.func = FUNC_NOP;
      r.pixel_index = window_pixel(w, h, ox, oy);
      return r;
   endfunction

   task automatic send_command(input req_type r);
      int gap;
      if (r.func == FUNC_TRIANGLE) begin
         triangle_count++;
         last_triangle = r;
      end
      req_data  <= r;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_simple(input func_type f, input logic [15:0] pix, input logic [11:0] face);
      req_type r;
      r = '0;
      r.func = f;
      r.pixel_index = pix;
      r.face_number = face;
      send_command(r);
   endtask

   task automatic send_triangle(input int x0, y0, x1, y1, x2, y2,
                                input logic [31:0] za, zb, zc, input logic [11:0] face);
      req_type r;
      r = '0;
      r.func = FUNC_TRIANGLE;
      r.vx0 = 16'(x0); r.vy0 = 16'(y0); r.vx1 = 16'(x1);
      r.vy1 = 16'(y1); r.vx2 = 16'(x2); r.vy2 = 16'(y2);
      r.depth_a = za; r.depth_b = zb; r.depth_c = zc;
      r.face_number = face;
      send_command(r);
   endtask

   task automatic write_register(input csr_type idx, input logic [8:0] value);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (got_count != sent_count) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   initial begin
      int g, run;
      rsp_ready = 0;
      held = 0;
      wait (reset === 0);
      forever begin
         run = $urandom_range(0, 9) < 2 ? $urandom_range(100, 300) : $urandom_range(1, 20);
         rsp_ready <= 1;
         repeat (run) @(posedge clock);
         if (!held && got_count >= 150) begin
            held = 1;
            rsp_ready <= 0;
            repeat (4000) @(posedge clock);
         end else begin
            g = pick_gap();
            if (g > 0) begin
               rsp_ready <= 0;
               repeat (g) @(posedge clock);
            end
         end
      end
   end

   initial begin
      int w, h, ox, oy;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_we = 0;
      csr_index = CSR_WIDTH;
      csr_wdata = '0;
      cycle_count = 0;
      sent_count = 0;
      got_count = 0;
      triangle_count = 0;
      last_triangle = '0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part on a three by two image.
      write_register(CSR_WIDTH, 9'd3);
      write_register(CSR_HEIGHT, 9'd2);
      for (int i = 0; i < 6; i++) send_simple(FUNC_MASK_SET, i, 0);
      send_simple(FUNC_MASK_SET, 16'hFFFF, 0);
      send_triangle(-32768, -32768, 32767, -32768, -32768, 32767,
                    32'd1, 32'hFFFF_FFFF, 32'h1_0000, 12'd7);
      send_triangle(0, 0, 40, 0, 0, 24, 32'h1_0000, 32'h1_0000, 32'h1_0000, 12'd4095);
      send_triangle(0, 0, 40, 0, 0, 24, 32'h1_0000, 32'h1_0000, 32'h1_0000, 12'd0);
      send_triangle(0, 0, 16, 16, 32, 32, 32'h1_0000, 32'h1_0000, 32'h1_0000, 12'd1);
      send_triangle(0, 0, 32, 0, 0, 16, 32'd0, 32'h1_0000, 32'h1_0000, 12'd2);
      send_triangle(-100, -100, -20, -90, -50, -20, 32'h1_0000, 32'h1_0000, 32'h1_0000, 12'd3);
      send_simple(FUNC_MASK_CLR, 0, 0);
      send_simple(FUNC_READ_PIXEL, 0, 0);
      send_simple(FUNC_READ_PIXEL, 1, 0);
      send_simple(FUNC_READ_PIXEL, 16'hFFFF, 0);
      send_simple(FUNC_FINISH, 0, 0);
      send_simple(FUNC_FACE_QUERY, 0, 12'd0);
      send_simple(FUNC_FACE_QUERY, 0, 12'd4095);
      send_simple(FUNC_NOP, 0, 0);
      send_simple(FUNC_CLEAR, 0, 0);
      send_simple(FUNC_FACE_QUERY, 0, 12'd0);

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         write_register(CSR_WIDTH, width_list[ph]);
         write_register(CSR_HEIGHT, height_list[ph]);
         w = dim_in_use(width_list[ph]);
         h = dim_in_use(height_list[ph]);
         ox = $urandom_range(0, w - 1);
         oy = $urandom_range(0, h - 1);
         if (ph % 2 == 0) send_simple(FUNC_CLEAR, 0, 0);
         for (int i = 0; i < 190; i++) send_command(make_command(w, h, ox, oy));
         send_simple(FUNC_FINISH, 0, 0);
      end

      wait_drained();
      repeat (100) @(posedge clock);
      $display("Covered %0d commands, %0d of them triangles, over %0d image sizes,",
               sent_count, triangle_count, PHASES + 1);
      $display("with random stalls on both channels and one long result hold-off.");
      if (fail_count == 0 && got_count == sent_count) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
